@@ hw/rtl/rtmd_pkg.sv @@
// Shared types and codes for the route table with minimum-distance lookup.
// Used by rtmd_cell, rtmd_scan and route_table_min_distance; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtmd_pkg;

  // Default table size.
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // A distance of this value is never reported as a route.
  localparam logic [15:0] NO_ROUTE_DIST = 16'hFFFF;

  // Request kinds, carried on in_tuser.
  typedef enum logic [1:0] {
    KIND_REM_GW   = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_REM_DEST = 2'd2,
    KIND_FIND     = 2'd3
  } req_kind_t;

  // Result status, carried on out_tuser.
  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FOUND   = 3'd1,
    ST_NONE    = 3'd2,
    ST_IGNORED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // One route entry as held in a cell.
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gateway;
    logic [15:0] link;
    logic [15:0] distance;
  } route_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK,
    CELL_ROTATE,
    CELL_PUSH,
    CELL_SWAP
  } cell_op_t;

  // Broadcast control for the cell chain.
  typedef struct packed {
    cell_op_t    op;
    logic        phase;       // swap phase: 0 pairs (0,1),(2,3)..; 1 pairs (1,2),(3,4)..
    logic        by_gateway;  // removal key compares the gateway, else the destination
    logic [31:0] key;
  } cell_ctl_t;

  // Control for the serial compare unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/rtmd_cell.sv @@
// One slot of the route table chain: holds an entry, a live flag and a tally bit.
// Depends on rtmd_pkg; instantiated in a row by route_table_min_distance.
`timescale 1ns / 1ps
`default_nettype none

module rtmd_cell import rtmd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned CELL_IDX    = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,     // this slot lies below the entry count
  input  wire route_t    lower_entry,  // from the newer neighbor (or the new route)
  input  wire logic      lower_live,
  input  wire route_t    upper_entry,  // from the older neighbor (wraps to the head)
  input  wire logic      upper_live,
  input  wire logic      upper_tally,
  output route_t         entry,
  output logic           live,
  output logic           tally
);

  localparam logic IDX_ODD = 1'((CELL_IDX % 2) == 1);
  localparam logic HAS_UP  = 1'((CELL_IDX + 1) < TABLE_DEPTH);
  localparam logic HAS_DN  = 1'(CELL_IDX > 0);

  route_t entry_r, entry_nxt;
  logic   live_r, live_nxt;
  logic   tally_r, tally_nxt;
  logic   key_hit;
  logic   is_lo;

  // Compare the removal key against this slot
  assign key_hit = ctl.by_gateway ? (entry_r.gateway == ctl.key) : (entry_r.dest == ctl.key);
  assign is_lo   = (IDX_ODD == ctl.phase);

  // Select the next slot contents
  always_comb begin
    entry_nxt = entry_r;
    live_nxt  = live_r;
    tally_nxt = tally_r;
    case (ctl.op)
      CELL_MARK: begin
        live_nxt  = occupied && !key_hit;
        tally_nxt = occupied && key_hit;
      end
      CELL_ROTATE: begin
        entry_nxt = upper_entry;
        live_nxt  = upper_live;
      end
      CELL_PUSH: begin
        entry_nxt = lower_entry;
        live_nxt  = lower_live;
      end
      CELL_SWAP: begin
        tally_nxt = upper_tally;
        // move a live entry down past a dead one, pairwise
        if (is_lo) begin
          if (HAS_UP && !live_r && upper_live) begin
            entry_nxt = upper_entry;
            live_nxt  = 1'b1;
          end
        end else if (HAS_DN && !lower_live && live_r) begin
          entry_nxt = lower_entry;
          live_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold slot flags; entry payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= 1'b0;
      tally_r <= 1'b0;
    end else begin
      live_r  <= live_nxt;
      tally_r <= tally_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign live  = live_r;
  assign tally = tally_r;

endmodule

`default_nettype wire

@@ hw/rtl/rtmd_scan.sv @@
// Serial compare unit at the head of the cell chain: best-route and duplicate search.
// Depends on rtmd_pkg; instantiated by route_table_min_distance.
`timescale 1ns / 1ps
`default_nettype none

module rtmd_scan import rtmd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire scan_ctl_t   ctl,
  input  wire route_t      head,       // entry currently in the head cell
  input  wire logic [31:0] req_dest,
  input  wire logic [31:0] req_gateway,
  input  wire logic [15:0] req_distance,
  output logic             hit,
  output logic             dup,
  output logic [31:0]      best_gateway,
  output logic [15:0]      best_link,
  output logic [15:0]      best_distance
);

  logic        hit_r, dup_r;
  logic [31:0] best_gw_r;
  logic [15:0] best_link_r;
  logic [15:0] best_dist_r;
  logic        dest_eq;
  logic        better;
  logic        same;

  assign dest_eq = (head.dest == req_dest);
  // strict compare keeps the newer entry on a tie and never takes the no-route distance
  assign better  = dest_eq && (head.distance < best_dist_r);
  assign same    = dest_eq && (head.gateway == req_gateway) && (head.distance == req_distance);

  // Track the best route and any duplicate as entries pass the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      dup_r       <= 1'b0;
      best_dist_r <= NO_ROUTE_DIST;
    end else if (ctl.clear) begin
      hit_r       <= 1'b0;
      dup_r       <= 1'b0;
      best_dist_r <= NO_ROUTE_DIST;
    end else if (ctl.step) begin
      if (better) begin
        hit_r       <= 1'b1;
        best_dist_r <= head.distance;
      end
      if (same) begin
        dup_r <= 1'b1;
      end
    end
    if (ctl.step && better) begin
      best_gw_r   <= head.gateway;
      best_link_r <= head.link;
    end
  end

  assign hit           = hit_r;
  assign dup           = dup_r;
  assign best_gateway  = best_gw_r;
  assign best_link     = best_link_r;
  assign best_distance = best_dist_r;

endmodule

`default_nettype wire

@@ hw/rtl/route_table_min_distance.sv @@
// Top level of the route table: request FSM, entry count, cell chain and compare unit.
// Depends on rtmd_pkg, rtmd_cell and rtmd_scan.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  in_     | in  | dest_addr, gateway_addr, gateway_link, hop_distance | kind
//  out_    | out | found_gateway, found_link, found_distance   | status
//
// Insert and find rotate the chain once through the head cell, one entry per cycle,
// past the compare unit. Removals run a marking step, then TABLE_DEPTH odd/even
// swap phases that close the gaps in the chain.
// One request is in work at a time; a result waiting on out_tready holds the chain.
// Reset empties the table; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module route_table_min_distance import rtmd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // dest_addr, gateway_addr, gateway_link, hop_distance
  input  wire logic [1:0]   in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // found_gateway, found_link, found_distance
  output logic [2:0]        out_tuser   // status
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_COMPACT,
    S_FINISH,
    S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;

  req_kind_t   req_kind_r, req_kind_nxt;
  logic [31:0] req_dest_r, req_dest_nxt;
  logic [31:0] req_gw_r, req_gw_nxt;
  logic [15:0] req_link_r, req_link_nxt;
  logic [15:0] req_dist_r, req_dist_nxt;

  status_t     res_status_r, res_status_nxt;
  logic [31:0] res_gw_r, res_gw_nxt;
  logic [15:0] res_link_r, res_link_nxt;
  logic [15:0] res_dist_r, res_dist_nxt;

  status_t     out_status_r, out_status_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic        in_fire;
  logic        push;
  cell_ctl_t   cell_ctl;
  scan_ctl_t   scan_ctl;
  route_t      new_entry;

  route_t      entry_q [TABLE_DEPTH];
  logic        live_q  [TABLE_DEPTH];
  logic        tally_q [TABLE_DEPTH];

  logic        scan_hit, scan_dup;
  logic [31:0] best_gw;
  logic [15:0] best_link, best_dist;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign new_entry = '{dest: req_dest_r, gateway: req_gw_r, link: req_link_r,
                       distance: req_dist_r};

  // Drive the chain from the request state
  always_comb begin
    cell_ctl.op         = CELL_HOLD;
    cell_ctl.phase      = step_r[0];
    cell_ctl.by_gateway = (req_kind_r == KIND_REM_GW);
    cell_ctl.key        = (req_kind_r == KIND_REM_GW) ? req_gw_r : req_dest_r;
    unique case (state_r)
      S_SCAN:    cell_ctl.op = CELL_ROTATE;
      S_MARK:    cell_ctl.op = CELL_MARK;
      S_COMPACT: cell_ctl.op = CELL_SWAP;
      S_FINISH:  cell_ctl.op = push ? CELL_PUSH : CELL_HOLD;
      default:   cell_ctl.op = CELL_HOLD;
    endcase
  end

  assign scan_ctl.clear = in_fire;
  assign scan_ctl.step  = (state_r == S_SCAN) && (step_r < count_r);

  // Build the row of cells; the oldest slot wraps back to the head
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    route_t lo_entry, up_entry;
    logic   lo_live, up_live, up_tally;

    if (i == 0) begin : g_head
      assign lo_entry = new_entry;
      assign lo_live  = 1'b1;
    end else begin : g_body
      assign lo_entry = entry_q[i-1];
      assign lo_live  = live_q[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign up_entry = entry_q[0];
      assign up_live  = live_q[0];
      assign up_tally = 1'b0;
    end else begin : g_mid
      assign up_entry = entry_q[i+1];
      assign up_live  = live_q[i+1];
      assign up_tally = tally_q[i+1];
    end

    rtmd_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .occupied    (CNT_W'(i) < count_r),
      .lower_entry (lo_entry),
      .lower_live  (lo_live),
      .upper_entry (up_entry),
      .upper_live  (up_live),
      .upper_tally (up_tally),
      .entry       (entry_q[i]),
      .live        (live_q[i]),
      .tally       (tally_q[i])
    );
  end

  rtmd_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (scan_ctl),
    .head          (entry_q[0]),
    .req_dest      (req_dest_r),
    .req_gateway   (req_gw_r),
    .req_distance  (req_dist_r),
    .hit           (scan_hit),
    .dup           (scan_dup),
    .best_gateway  (best_gw),
    .best_link     (best_link),
    .best_distance (best_dist)
  );

  // Sequence one request and stage its result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    req_kind_nxt   = req_kind_r;
    req_dest_nxt   = req_dest_r;
    req_gw_nxt     = req_gw_r;
    req_link_nxt   = req_link_r;
    req_dist_nxt   = req_dist_r;
    res_status_nxt = res_status_r;
    res_gw_nxt     = res_gw_r;
    res_link_nxt   = res_link_r;
    res_dist_nxt   = res_dist_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    push           = 1'b0;

    // drop a beat the sink has taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_kind_nxt = req_kind_t'(in_tuser);
          req_dest_nxt = in_tdata[31:0];
          req_gw_nxt   = in_tdata[63:32];
          req_link_nxt = in_tdata[79:64];
          req_dist_nxt = in_tdata[95:80];
          step_nxt     = '0;
          if (in_tuser == KIND_INSERT || in_tuser == KIND_FIND) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_C) begin
          state_nxt = S_FINISH;
        end
      end
      S_MARK: begin
        state_nxt = S_COMPACT;
      end
      S_COMPACT: begin
        // one removed slot leaves the head tally per cycle
        step_nxt  = step_r + 1'b1;
        count_nxt = count_r - CNT_W'(tally_q[0]);
        if (step_r == LAST_C) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        res_status_nxt = ST_DONE;
        res_gw_nxt     = '0;
        res_link_nxt   = '0;
        res_dist_nxt   = '0;
        unique case (req_kind_r) inside
          KIND_INSERT: begin
            if (req_link_r == '0 || scan_dup) begin
              res_status_nxt = ST_IGNORED;
            end else if (count_r == DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else begin
              push      = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          KIND_FIND: begin
            if (scan_hit) begin
              res_status_nxt = ST_FOUND;
              res_gw_nxt     = best_gw;
              res_link_nxt   = best_link;
              res_dist_nxt   = best_dist;
            end else begin
              res_status_nxt = ST_NONE;
            end
          end
          KIND_REM_GW, KIND_REM_DEST: begin
            res_status_nxt = ST_DONE;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {res_dist_r, res_link_r, res_gw_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, count and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_kind_r   <= req_kind_nxt;
    req_dest_r   <= req_dest_nxt;
    req_gw_r     <= req_gw_nxt;
    req_link_r   <= req_link_nxt;
    req_dist_r   <= req_dist_nxt;
    res_status_r <= res_status_nxt;
    res_gw_r     <= res_gw_nxt;
    res_link_r   <= res_link_nxt;
    res_dist_r   <= res_dist_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Entry count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds table depth");

  // A push into the chain never happens on a full table
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_ctl.op == CELL_PUSH) |-> (count_r < DEPTH_C))
    else $error("push into a full table");

  // Compaction only shrinks the table
  a_compact_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT) |=> (count_r <= $past(count_r)))
    else $error("entry count grew during removal");

  // A reported route never carries the no-route distance
  a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FOUND) |-> (out_tdata[63:48] != NO_ROUTE_DIST))
    else $error("found route with no-route distance");

endmodule

`default_nettype wire
